>>> src/mbd_pkg.sv
package mbd_pkg;

    localparam logic [62:0] SAT63 = {63{1'b1}};

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_BODY   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_CHUNK  = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    // Pattern positions for the Content-Range line; below PP_B_FIRST the
    // position indexes the literal prefix.
    localparam logic [4:0] PP_B_FIRST = 5'd21;
    localparam logic [4:0] PP_B_MORE  = 5'd22;
    localparam logic [4:0] PP_E_FIRST = 5'd23;
    localparam logic [4:0] PP_E_MORE  = 5'd24;
    localparam logic [4:0] PP_T_FIRST = 5'd25;
    localparam logic [4:0] PP_T_MORE  = 5'd26;
    localparam logic [4:0] PP_LF      = 5'd27;
    localparam logic [4:0] PP_MATCH   = 5'd28;
    localparam logic [4:0] PP_FAIL    = 5'd31;

    // Operation handed from the front to the back through the queue.
    typedef struct packed {
        logic       valid;
        cmd_t       cmd;
        logic [7:0] data;
    } op_t;

    function automatic logic [7:0] prefix_char(input logic [4:0] p);
        logic [7:0] r;
        unique case (p)
            5'd0:    r = "c";
            5'd1:    r = "o";
            5'd2:    r = "n";
            5'd3:    r = "t";
            5'd4:    r = "e";
            5'd5:    r = "n";
            5'd6:    r = "t";
            5'd7:    r = "-";
            5'd8:    r = "r";
            5'd9:    r = "a";
            5'd10:   r = "n";
            5'd11:   r = "g";
            5'd12:   r = "e";
            5'd13:   r = ":";
            5'd14:   r = " ";
            5'd15:   r = "b";
            5'd16:   r = "y";
            5'd17:   r = "t";
            5'd18:   r = "e";
            5'd19:   r = "s";
            5'd20:   r = " ";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // v*10+d, saturating at 2^63-1.
    function automatic logic [62:0] sat_digit(input logic [62:0] v, input logic [3:0] d);
        logic [66:0] s;
        s = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {63'd0, d};
        return (s > {4'd0, SAT63}) ? SAT63 : s[62:0];
    endfunction

endpackage

>>> src/mbd_if.sv
interface mbd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] byte_value;

    modport source (output valid, output command, output byte_value, input ready);
    modport sink (input valid, input command, input byte_value, output ready);
endinterface

interface mbd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [62:0] range_begin;
    logic [62:0] range_end;
    logic [31:0] chunk_offset;
    logic [62:0] total_bytes;

    modport source (output valid, output kind, output data_byte, output range_begin,
                    output range_end, output chunk_offset, output total_bytes,
                    input ready);
    modport sink (input valid, input kind, input data_byte, input range_begin,
                  input range_end, input chunk_offset, input total_bytes,
                  output ready);
endinterface

>>> src/mbd_front.sv
module mbd_front (
    input  logic          clk,
    input  logic          rst_n,
    mbd_in_if.sink        item,
    output mbd_pkg::op_t  op,
    input  logic          pop
);

    // Two-entry queue of classified operations.
    mbd_pkg::cmd_t  cmd_reg  [2];
    logic [7:0]     data_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push;
    logic           do_pop;
    mbd_pkg::cmd_t  cmd_in;

    assign cmd_in     = mbd_pkg::cmd_t'(item.command);
    assign item.ready = (count_reg != 2'd2);
    // Command code three has no effect, so it is dropped here.
    assign push       = item.valid && item.ready && (cmd_in != mbd_pkg::CMD_NONE);
    assign do_pop     = pop && (count_reg != 2'd0);

    assign op = '{valid: (count_reg != 2'd0),
                  cmd:   cmd_reg[rd_ptr_reg],
                  data:  data_reg[rd_ptr_reg]};

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_reg[wr_ptr_reg]  <= cmd_in;
            data_reg[wr_ptr_reg] <= item.byte_value;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

>>> src/mbd_back.sv
module mbd_back #(
    parameter int MAX_BOUNDARY    = 128,
    parameter int MAX_HEADER_LINE = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  mbd_pkg::op_t  op,
    output logic          pop,
    mbd_out_if.source     result
);

    localparam int AW = (MAX_BOUNDARY > 1) ? $clog2(MAX_BOUNDARY) : 1;
    localparam int BW = $clog2(MAX_BOUNDARY + 1);
    localparam int LW = $clog2(MAX_HEADER_LINE + 1);

    typedef enum logic [2:0] {
        PH_PAIR, PH_BOUND, PH_CLOSE, PH_HEADER, PH_DATA, PH_DONE, PH_ERROR
    } phase_t;

    logic [7:0] bstore [MAX_BOUNDARY];
    logic [7:0] bread_reg;

    phase_t       phase_reg, phase_next;
    logic [7:0]   pair_first_reg, pair_first_next;
    logic         pair_count_reg, pair_count_next;
    logic [BW-1:0] blen_reg, blen_next;
    logic [BW-1:0] bidx_reg, bidx_next;
    logic [LW-1:0] line_len_reg, line_len_next;
    logic [4:0]   pp_reg, pp_next;
    logic         prev_cr_reg, prev_cr_next;
    logic [62:0]  cand_b_reg, cand_b_next;
    logic [62:0]  cand_e_reg, cand_e_next;
    logic [62:0]  chunk_b_reg, chunk_b_next;
    logic [62:0]  chunk_e_reg, chunk_e_next;
    logic [62:0]  chunk_len_reg, chunk_len_next;
    logic [62:0]  left_reg, left_next;
    logic [31:0]  pos_reg, pos_next;
    logic [62:0]  total_reg, total_next;

    logic         ovalid_reg, ovalid_next;
    mbd_pkg::kind_t kind_reg, kind_next;
    logic [7:0]   odata_reg, odata_next;
    logic [62:0]  obegin_reg, obegin_next;
    logic [62:0]  oend_reg, oend_next;
    logic [31:0]  ooff_reg, ooff_next;
    logic [62:0]  ototal_reg, ototal_next;

    logic         wr_en;
    logic [7:0]   c;
    logic         dig;
    logic [3:0]   dval;
    logic [7:0]   lc;
    logic         term;
    logic [LW-1:0] ll;
    logic [62:0]  diff;
    logic [63:0]  tsum;

    assign pop = op.valid && (!ovalid_reg || result.ready);
    assign c   = op.data;
    assign dig = (c >= "0") && (c <= "9");
    assign dval = dig ? 4'(c - "0") : 4'd0;
    assign lc  = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    assign wr_en = pop && (op.cmd == mbd_pkg::CMD_APPEND)
                   && (blen_reg < BW'(MAX_BOUNDARY));
    assign diff = cand_e_reg - cand_b_reg;
    assign tsum = {1'b0, total_reg} + {1'b0, chunk_len_reg};

    always_comb
    begin
        phase_next      = phase_reg;
        pair_first_next = pair_first_reg;
        pair_count_next = pair_count_reg;
        blen_next       = blen_reg;
        bidx_next       = bidx_reg;
        line_len_next   = line_len_reg;
        pp_next         = pp_reg;
        prev_cr_next    = prev_cr_reg;
        cand_b_next     = cand_b_reg;
        cand_e_next     = cand_e_reg;
        chunk_b_next    = chunk_b_reg;
        chunk_e_next    = chunk_e_reg;
        chunk_len_next  = chunk_len_reg;
        left_next       = left_reg;
        pos_next        = pos_reg;
        total_next      = total_reg;
        ovalid_next     = ovalid_reg && !result.ready;
        kind_next       = kind_reg;
        odata_next      = odata_reg;
        obegin_next     = obegin_reg;
        oend_next       = oend_reg;
        ooff_next       = ooff_reg;
        ototal_next     = ototal_reg;
        term            = 1'b0;
        ll              = line_len_reg + LW'(1);

        if (pop)
        begin
            ovalid_next = 1'b0;
            unique case (op.cmd)
                mbd_pkg::CMD_START:
                begin
                    phase_next      = PH_PAIR;
                    pair_first_next = 8'd0;
                    pair_count_next = 1'b0;
                    blen_next       = '0;
                    bidx_next       = '0;
                    line_len_next   = '0;
                    pp_next         = 5'd0;
                    prev_cr_next    = 1'b0;
                    cand_b_next     = '0;
                    cand_e_next     = '0;
                    chunk_b_next    = '0;
                    chunk_e_next    = '0;
                    chunk_len_next  = 63'd1;
                    left_next       = '0;
                    pos_next        = '0;
                    total_next      = '0;
                end
                mbd_pkg::CMD_APPEND:
                begin
                    if (wr_en)
                        blen_next = blen_reg + BW'(1);
                end
                mbd_pkg::CMD_BODY:
                begin
                    if (phase_reg != PH_DONE && phase_reg != PH_ERROR)
                    begin
                        pos_next    = pos_reg + 32'd1;
                        odata_next  = 8'd0;
                        obegin_next = '0;
                        oend_next   = '0;
                        ooff_next   = '0;
                        unique case (phase_reg)
                            PH_PAIR, PH_CLOSE:
                            begin
                                if (!pair_count_reg)
                                begin
                                    pair_first_next = c;
                                    pair_count_next = 1'b1;
                                end
                                else
                                begin
                                    pair_count_next = 1'b0;
                                    if (pair_first_reg == mbd_pkg::CH_CR && c == mbd_pkg::CH_LF)
                                    begin
                                        if (phase_reg == PH_CLOSE)
                                        begin
                                            phase_next    = PH_HEADER;
                                            line_len_next = '0;
                                            pp_next       = 5'd0;
                                            prev_cr_next  = 1'b0;
                                            cand_b_next   = '0;
                                            cand_e_next   = '0;
                                        end
                                    end
                                    else if (pair_first_reg == mbd_pkg::CH_DASH
                                             && c == mbd_pkg::CH_DASH)
                                    begin
                                        if (phase_reg == PH_CLOSE)
                                        begin
                                            phase_next  = PH_DONE;
                                            kind_next   = mbd_pkg::KIND_FINISH;
                                            ovalid_next = 1'b1;
                                        end
                                        else if (blen_reg == '0)
                                            phase_next = PH_CLOSE;
                                        else
                                        begin
                                            phase_next = PH_BOUND;
                                            bidx_next  = '0;
                                        end
                                    end
                                    else
                                    begin
                                        phase_next  = PH_ERROR;
                                        kind_next   = mbd_pkg::KIND_ERROR;
                                        ovalid_next = 1'b1;
                                    end
                                end
                            end
                            PH_BOUND:
                            begin
                                if (bidx_reg >= BW'(MAX_BOUNDARY) || bread_reg != c)
                                begin
                                    phase_next  = PH_ERROR;
                                    kind_next   = mbd_pkg::KIND_ERROR;
                                    ovalid_next = 1'b1;
                                end
                                else
                                begin
                                    bidx_next = bidx_reg + BW'(1);
                                    if (bidx_reg + BW'(1) >= blen_reg)
                                    begin
                                        phase_next      = PH_CLOSE;
                                        pair_count_next = 1'b0;
                                    end
                                end
                            end
                            PH_HEADER:
                            begin
                                term          = prev_cr_reg && c == mbd_pkg::CH_LF;
                                prev_cr_next  = (c == mbd_pkg::CH_CR);
                                line_len_next = ll;
                                if (pp_reg < mbd_pkg::PP_B_FIRST)
                                    pp_next = (lc == mbd_pkg::prefix_char(pp_reg))
                                              ? pp_reg + 5'd1 : mbd_pkg::PP_FAIL;
                                else if (pp_reg == mbd_pkg::PP_B_FIRST
                                         || pp_reg == mbd_pkg::PP_B_MORE)
                                begin
                                    if (dig)
                                    begin
                                        cand_b_next = mbd_pkg::sat_digit(cand_b_reg, dval);
                                        pp_next     = mbd_pkg::PP_B_MORE;
                                    end
                                    else
                                        pp_next = (pp_reg == mbd_pkg::PP_B_MORE
                                                   && c == mbd_pkg::CH_DASH)
                                                  ? mbd_pkg::PP_E_FIRST : mbd_pkg::PP_FAIL;
                                end
                                else if (pp_reg == mbd_pkg::PP_E_FIRST
                                         || pp_reg == mbd_pkg::PP_E_MORE)
                                begin
                                    if (dig)
                                    begin
                                        cand_e_next = mbd_pkg::sat_digit(cand_e_reg, dval);
                                        pp_next     = mbd_pkg::PP_E_MORE;
                                    end
                                    else
                                        pp_next = (pp_reg == mbd_pkg::PP_E_MORE
                                                   && c == mbd_pkg::CH_SLASH)
                                                  ? mbd_pkg::PP_T_FIRST : mbd_pkg::PP_FAIL;
                                end
                                else if (pp_reg == mbd_pkg::PP_T_FIRST
                                         || pp_reg == mbd_pkg::PP_T_MORE)
                                begin
                                    if (dig)
                                        pp_next = mbd_pkg::PP_T_MORE;
                                    else
                                        pp_next = (pp_reg == mbd_pkg::PP_T_MORE
                                                   && c == mbd_pkg::CH_CR)
                                                  ? mbd_pkg::PP_LF : mbd_pkg::PP_FAIL;
                                end
                                else if (pp_reg == mbd_pkg::PP_LF)
                                    pp_next = (c == mbd_pkg::CH_LF)
                                              ? mbd_pkg::PP_MATCH : mbd_pkg::PP_FAIL;
                                else
                                    pp_next = mbd_pkg::PP_FAIL;

                                if (term || ll >= LW'(MAX_HEADER_LINE))
                                begin
                                    if (term && ll == LW'(2))
                                    begin
                                        // Blank line: the chunk length was worked out
                                        // when its range was latched.
                                        total_next = tsum[62:0] > mbd_pkg::SAT63 - 63'd0
                                                     || tsum[63] ? mbd_pkg::SAT63
                                                     : tsum[62:0];
                                        left_next       = chunk_len_reg;
                                        obegin_next     = chunk_b_reg;
                                        oend_next       = chunk_e_reg;
                                        ooff_next       = pos_reg + 32'd1;
                                        kind_next       = mbd_pkg::KIND_CHUNK;
                                        ovalid_next     = 1'b1;
                                        phase_next      = (chunk_len_reg == '0)
                                                          ? PH_PAIR : PH_DATA;
                                        pair_count_next = 1'b0;
                                    end
                                    else if (pp_next == mbd_pkg::PP_MATCH)
                                    begin
                                        chunk_b_next = cand_b_reg;
                                        chunk_e_next = cand_e_reg;
                                        if (cand_e_reg < cand_b_reg)
                                            chunk_len_next = '0;
                                        else if (diff == mbd_pkg::SAT63)
                                            chunk_len_next = mbd_pkg::SAT63;
                                        else
                                            chunk_len_next = diff + 63'd1;
                                    end
                                    line_len_next = '0;
                                    pp_next       = 5'd0;
                                    prev_cr_next  = 1'b0;
                                    cand_b_next   = '0;
                                    cand_e_next   = '0;
                                end
                            end
                            PH_DATA:
                            begin
                                odata_next  = c;
                                kind_next   = mbd_pkg::KIND_DATA;
                                ovalid_next = 1'b1;
                                left_next   = left_reg - 63'd1;
                                if (left_reg == 63'd1)
                                begin
                                    phase_next      = PH_PAIR;
                                    pair_count_next = 1'b0;
                                end
                            end
                            default:
                                phase_next = PH_ERROR;
                        endcase
                        ototal_next = total_next;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_PAIR;
            pair_first_reg <= 8'd0;
            pair_count_reg <= 1'b0;
            blen_reg       <= '0;
            bidx_reg       <= '0;
            line_len_reg   <= '0;
            pp_reg         <= 5'd0;
            prev_cr_reg    <= 1'b0;
            cand_b_reg     <= '0;
            cand_e_reg     <= '0;
            chunk_b_reg    <= '0;
            chunk_e_reg    <= '0;
            chunk_len_reg  <= 63'd1;
            left_reg       <= '0;
            pos_reg        <= '0;
            total_reg      <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pair_first_reg <= pair_first_next;
            pair_count_reg <= pair_count_next;
            blen_reg       <= blen_next;
            bidx_reg       <= bidx_next;
            line_len_reg   <= line_len_next;
            pp_reg         <= pp_next;
            prev_cr_reg    <= prev_cr_next;
            cand_b_reg     <= cand_b_next;
            cand_e_reg     <= cand_e_next;
            chunk_b_reg    <= chunk_b_next;
            chunk_e_reg    <= chunk_e_next;
            chunk_len_reg  <= chunk_len_next;
            left_reg       <= left_next;
            pos_reg        <= pos_next;
            total_reg      <= total_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        odata_reg  <= odata_next;
        obegin_reg <= obegin_next;
        oend_reg   <= oend_next;
        ooff_reg   <= ooff_next;
        ototal_reg <= ototal_next;
    end

    // Boundary memory. The read is registered from the next match index,
    // with a bypass when that entry is being written.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            bstore[blen_reg[AW-1:0]] <= c;
        if (wr_en && blen_reg == bidx_next)
            bread_reg <= c;
        else
            bread_reg <= bstore[bidx_next[AW-1:0]];
    end

    assign result.valid        = ovalid_reg;
    assign result.kind         = kind_reg;
    assign result.data_byte    = odata_reg;
    assign result.range_begin  = obegin_reg;
    assign result.range_end    = oend_reg;
    assign result.chunk_offset = ooff_reg;
    assign result.total_bytes  = ototal_reg;

    a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> left_reg != '0)
        else $error("data phase with nothing left");

    a_blen_max: assert property (@(posedge clk) disable iff (!rst_n)
        blen_reg <= BW'(MAX_BOUNDARY))
        else $error("boundary length beyond capacity");

    a_bidx_in: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BOUND |-> bidx_reg < blen_reg)
        else $error("boundary index past boundary length");

    a_no_pop_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !result.ready) |-> !pop)
        else $error("operation taken while result is held");

endmodule

>>> src/multipart_byterange_deframer.sv
// Channel  Dir  Payload                                               Transfer
// item     in   command[1:0], byte_value[7:0]                          valid & ready
// result   out  kind, data_byte, range_begin, range_end,               valid & ready
//               chunk_offset, total_bytes
//
// One item per cycle sustained while results are taken; the parser handles one body byte per pop.
// An accepted item is written into the front queue, then popped into the result register once it is free.
// The front queue holds two items, so input is taken while a result waits.
// rst_n is asynchronous; no clearing pass, the boundary memory is not reset.
// A stalled result holds the parser; the queue absorbs up to two more items.
module multipart_byterange_deframer #(
    parameter int MAX_BOUNDARY    = 128,
    parameter int MAX_HEADER_LINE = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    mbd_in_if.sink    item,
    mbd_out_if.source result
);

    mbd_pkg::op_t op;
    logic         pop;

    mbd_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .op    (op),
        .pop   (pop)
    );

    mbd_back #(
        .MAX_BOUNDARY    (MAX_BOUNDARY),
        .MAX_HEADER_LINE (MAX_HEADER_LINE)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .pop    (pop),
        .result (result)
    );

endmodule

>>> verif/multipart_byterange_deframer_test.sv
module multipart_byterange_deframer_test;

    localparam int BOUNDARY_DEPTH = 128;
    localparam int LINE_LIMIT     = 1024;
    localparam int TARGET_ITEMS   = 1500;

    typedef enum logic [3:0] {
        P_PAIR, P_BOUND, P_CLOSE, P_HEADER, P_DATA, P_DONE, P_ERROR
    } phase_t;

    typedef struct {
        bit            hold;
        mbd_pkg::cmd_t cmd;
        logic [7:0]    val;
    } pending_t;

    typedef struct {
        mbd_pkg::kind_t kind;
        logic [7:0]     data;
        logic [62:0]    rbegin;
        logic [62:0]    rend;
        logic [31:0]    offset;
        logic [62:0]    total;
    } frame_event_t;

    logic clk = 1'b0;
    logic rst_n;

    mbd_in_if  item_ch ();
    mbd_out_if result_ch ();

    multipart_byterange_deframer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always #1 clk = ~clk;

    pending_t     pending_items[$];
    frame_event_t expected_events[$];
    int           error_count = 0;
    int           accepted_count = 0;
    int           send_gap, recv_gap;
    bit           send_burst, recv_burst;
    logic         rx_hold = 1'b0;

    // Deframer state mirrored for prediction.
    phase_t      phase;
    logic [7:0]  pair_first;
    bit          pair_half;
    logic [7:0]  bound_mem[BOUNDARY_DEPTH];
    int          bound_len, bound_pos, line_len;
    logic [4:0]  pat_pos;
    bit          last_cr;
    logic [62:0] cand_begin, cand_end, chunk_begin, chunk_end, remaining, sum_total;
    logic [31:0] body_pos;

    string prefix_text = "content-range: bytes ";

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic logic [62:0] decimal_shift(input logic [62:0] v, input int d);
        logic [63:0] lim;
        lim = ({1'b0, mbd_pkg::SAT63} - d) / 10;
        if ({1'b0, v} > lim)
            return mbd_pkg::SAT63;
        return v * 10 + d;
    endfunction

    task automatic clear_body();
        phase = P_PAIR;
        pair_first = 8'd0;
        pair_half = 1'b0;
        bound_len = 0;
        bound_pos = 0;
        line_len = 0;
        pat_pos = 5'd0;
        last_cr = 1'b0;
        cand_begin = '0;
        cand_end = '0;
        chunk_begin = '0;
        chunk_end = '0;
        remaining = '0;
        body_pos = '0;
        sum_total = '0;
    endtask

    task automatic match_range_char(input logic [7:0] c);
        bit         dig;
        int         d;
        logic [7:0] lc;
        dig = (c >= "0" && c <= "9");
        d = dig ? int'(c) - int'("0") : 0;
        if (pat_pos < mbd_pkg::PP_B_FIRST)
        begin
            lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
            pat_pos = (lc == prefix_text[pat_pos]) ? pat_pos + 5'd1 : mbd_pkg::PP_FAIL;
        end
        else if (pat_pos == mbd_pkg::PP_B_FIRST || pat_pos == mbd_pkg::PP_B_MORE)
        begin
            if (dig)
            begin
                cand_begin = decimal_shift(cand_begin, d);
                pat_pos = mbd_pkg::PP_B_MORE;
            end
            else
                pat_pos = (pat_pos == mbd_pkg::PP_B_MORE && c == mbd_pkg::CH_DASH)
                          ? mbd_pkg::PP_E_FIRST : mbd_pkg::PP_FAIL;
        end
        else if (pat_pos == mbd_pkg::PP_E_FIRST || pat_pos == mbd_pkg::PP_E_MORE)
        begin
            if (dig)
            begin
                cand_end = decimal_shift(cand_end, d);
                pat_pos = mbd_pkg::PP_E_MORE;
            end
            else
                pat_pos = (pat_pos == mbd_pkg::PP_E_MORE && c == mbd_pkg::CH_SLASH)
                          ? mbd_pkg::PP_T_FIRST : mbd_pkg::PP_FAIL;
        end
        else if (pat_pos == mbd_pkg::PP_T_FIRST || pat_pos == mbd_pkg::PP_T_MORE)
        begin
            if (dig)
                pat_pos = mbd_pkg::PP_T_MORE;
            else
                pat_pos = (pat_pos == mbd_pkg::PP_T_MORE && c == mbd_pkg::CH_CR)
                          ? mbd_pkg::PP_LF : mbd_pkg::PP_FAIL;
        end
        else if (pat_pos == mbd_pkg::PP_LF)
            pat_pos = (c == mbd_pkg::CH_LF) ? mbd_pkg::PP_MATCH : mbd_pkg::PP_FAIL;
        else
            pat_pos = mbd_pkg::PP_FAIL;
    endtask

    task automatic push_event(input mbd_pkg::kind_t k, input logic [7:0] data,
                              input logic [62:0] rb, input logic [62:0] re,
                              input logic [31:0] off);
        frame_event_t ev;
        ev.kind = k;
        ev.data = data;
        ev.rbegin = rb;
        ev.rend = re;
        ev.offset = off;
        ev.total = sum_total;
        expected_events = {expected_events, ev};
    endtask

    task automatic deframe_step(input mbd_pkg::cmd_t cmd, input logic [7:0] c);
        bit          ends_line;
        logic [63:0] span;
        logic [62:0] len;
        if (cmd == mbd_pkg::CMD_START)
        begin
            clear_body();
            return;
        end
        if (cmd == mbd_pkg::CMD_APPEND)
        begin
            if (bound_len < BOUNDARY_DEPTH)
            begin
                bound_mem[bound_len] = c;
                bound_len++;
            end
            return;
        end
        if (cmd != mbd_pkg::CMD_BODY || phase == P_DONE || phase == P_ERROR)
            return;
        body_pos = body_pos + 32'd1;
        case (phase)
            P_PAIR, P_CLOSE:
            begin
                if (!pair_half)
                begin
                    pair_first = c;
                    pair_half = 1'b1;
                end
                else
                begin
                    pair_half = 1'b0;
                    if (pair_first == mbd_pkg::CH_CR && c == mbd_pkg::CH_LF)
                    begin
                        if (phase == P_CLOSE)
                        begin
                            phase = P_HEADER;
                            line_len = 0;
                            pat_pos = 5'd0;
                            last_cr = 1'b0;
                            cand_begin = '0;
                            cand_end = '0;
                        end
                    end
                    else if (pair_first == mbd_pkg::CH_DASH && c == mbd_pkg::CH_DASH)
                    begin
                        if (phase == P_CLOSE)
                        begin
                            phase = P_DONE;
                            push_event(mbd_pkg::KIND_FINISH, '0, '0, '0, '0);
                        end
                        else if (bound_len == 0)
                            phase = P_CLOSE;
                        else
                        begin
                            phase = P_BOUND;
                            bound_pos = 0;
                        end
                    end
                    else
                    begin
                        phase = P_ERROR;
                        push_event(mbd_pkg::KIND_ERROR, '0, '0, '0, '0);
                    end
                end
            end
            P_BOUND:
            begin
                if (bound_pos >= BOUNDARY_DEPTH || bound_mem[bound_pos] != c)
                begin
                    phase = P_ERROR;
                    push_event(mbd_pkg::KIND_ERROR, '0, '0, '0, '0);
                end
                else
                begin
                    bound_pos++;
                    if (bound_pos >= bound_len)
                    begin
                        phase = P_CLOSE;
                        pair_half = 1'b0;
                    end
                end
            end
            P_HEADER:
            begin
                ends_line = last_cr && c == mbd_pkg::CH_LF;
                last_cr = (c == mbd_pkg::CH_CR);
                line_len++;
                match_range_char(c);
                if (ends_line || line_len >= LINE_LIMIT)
                begin
                    if (ends_line && line_len == 2)
                    begin
                        len = '0;
                        if (chunk_end >= chunk_begin)
                        begin
                            span = chunk_end - chunk_begin;
                            len = (span >= mbd_pkg::SAT63) ? mbd_pkg::SAT63
                                                           : span[62:0] + 63'd1;
                        end
                        sum_total = (sum_total > mbd_pkg::SAT63 - len) ? mbd_pkg::SAT63
                                                                       : sum_total + len;
                        remaining = len;
                        push_event(mbd_pkg::KIND_CHUNK, '0, chunk_begin, chunk_end, body_pos);
                        phase = (len == 0) ? P_PAIR : P_DATA;
                        pair_half = 1'b0;
                    end
                    else if (pat_pos == mbd_pkg::PP_MATCH)
                    begin
                        chunk_begin = cand_begin;
                        chunk_end = cand_end;
                    end
                    line_len = 0;
                    pat_pos = 5'd0;
                    last_cr = 1'b0;
                    cand_begin = '0;
                    cand_end = '0;
                end
            end
            P_DATA:
            begin
                push_event(mbd_pkg::KIND_DATA, c, '0, '0, '0);
                remaining = remaining - 63'd1;
                if (remaining == 0)
                begin
                    phase = P_PAIR;
                    pair_half = 1'b0;
                end
            end
            default:
                phase = P_ERROR;
        endcase
    endtask

    // Stimulus construction.
    int stim_items = 0;

    task automatic queue_item(input mbd_pkg::cmd_t cmd, input logic [7:0] v);
        pending_t p;
        p.hold = 1'b0;
        p.cmd = cmd;
        p.val = v;
        pending_items = {pending_items, p};
        if (cmd != mbd_pkg::CMD_NONE)
            stim_items++;
    endtask

    task automatic queue_drain();
        pending_t p;
        p.hold = 1'b1;
        p.cmd = mbd_pkg::CMD_NONE;
        p.val = '0;
        pending_items = {pending_items, p};
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_item(mbd_pkg::CMD_BODY, s[i]);
    endtask

    function automatic string mixed_case(input string s);
        string r;
        byte   ch;
        r = s;
        for (int i = 0; i < r.len(); i++)
        begin
            ch = r[i];
            if (ch >= "a" && ch <= "z" && $urandom_range(0, 1))
                r[i] = ch - 8'd32;
        end
        return r;
    endfunction

    task automatic add_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++)
            q = {q, s[i]};
    endtask

    task automatic add_delim(ref logic [7:0] q[$], ref logic [7:0] bnd[$]);
        add_text(q, "--");
        foreach (bnd[i])
            if (i < BOUNDARY_DEPTH)
                q = {q, bnd[i]};
    endtask

    task automatic build_body(input bit long_line);
        logic [7:0] bnd[$];
        logic [7:0] stream[$];
        int         blen, parts, span_mode, b, e, nbytes, late_pos;
        logic [7:0] late_byte;
        string      nines;
        bit         cut_short;
        nines = "9999999999999999999999999";
        cut_short = 1'b0;
        late_pos = -1;
        case ($urandom_range(0, 9))
            0:       blen = 0;
            1:       blen = $urandom_range(128, 134);
            2:       blen = $urandom_range(30, 70);
            default: blen = $urandom_range(1, 12);
        endcase
        queue_item(mbd_pkg::CMD_START, 8'($urandom));
        for (int i = 0; i < blen; i++)
        begin
            bnd = {bnd, 8'($urandom)};
            queue_item(mbd_pkg::CMD_APPEND, bnd[i]);
        end
        repeat ($urandom_range(0, 2))
            add_text(stream, "\r\n");
        parts = $urandom_range(0, 3);
        for (int p = 0; p < parts && !cut_short; p++)
        begin
            // A boundary byte appended mid-body lengthens the delimiter.
            if (late_pos < 0 && $urandom_range(0, 19) == 0)
            begin
                late_pos = stream.size();
                late_byte = 8'($urandom);
                bnd = {bnd, late_byte};
            end
            add_delim(stream, bnd);
            add_text(stream, "\r\n");
            if ($urandom_range(0, 2) == 0)
                add_text(stream, {mixed_case("content-type: text/x"), "\r\n"});
            if (long_line && p == 0)
            begin
                repeat (LINE_LIMIT + 6)
                    stream = {stream, 8'h61};
                add_text(stream, "\r\n");
            end
            span_mode = $urandom_range(0, 29);
            if (span_mode == 0)
            begin
                add_text(stream, {mixed_case("content-range: bytes "), nines, "-", nines,
                                  "/", nines, "\r\n"});
                nbytes = 1;
            end
            else if (span_mode == 1)
            begin
                add_text(stream, {mixed_case("content-range: bytes "), "0-", nines,
                                  "/1\r\n"});
                nbytes = 6;
                cut_short = 1'b1;
            end
            else if (span_mode < 5)
                nbytes = 0;
            else
            begin
                b = $urandom_range(0, 30);
                e = b + $urandom_range(0, 8) - 2;
                if (e < 0)
                    e = 0;
                nbytes = (e < b) ? 0 : e - b + 1;
                add_text(stream, {mixed_case("content-range: bytes "),
                                  $sformatf("%0d-%0d/%0d", b, e, $urandom_range(1, 999)),
                                  ($urandom_range(0, 7) == 0) ? string'("\r\r\n")
                                                              : string'("\r\n")});
                if ($urandom_range(0, 7) == 0)
                    nbytes = 0;
            end
            add_text(stream, "\r\n");
            // Without a fresh range line the last one latched still governs.
            if (span_mode >= 2 && span_mode < 5)
                nbytes = -1;
            if (nbytes > 0)
                repeat (nbytes)
                    stream = {stream, 8'($urandom)};
            if (!cut_short)
                add_text(stream, "\r\n");
        end
        if (!cut_short)
        begin
            add_delim(stream, bnd);
            add_text(stream, "--");
            repeat ($urandom_range(0, 2))
                stream = {stream, 8'($urandom)};
        end
        if ($urandom_range(0, 6) == 0 && stream.size() > 0)
            stream[$urandom_range(0, stream.size() - 1)] = 8'($urandom);
        foreach (stream[i])
        begin
            if (i == late_pos)
                queue_item(mbd_pkg::CMD_APPEND, late_byte);
            if ($urandom_range(0, 99) == 0)
                queue_item(mbd_pkg::CMD_NONE, 8'($urandom));
            queue_item(mbd_pkg::CMD_BODY, stream[i]);
        end
    endtask

    // Sender.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_ch.command <= mbd_pkg::CMD_NONE;
            item_ch.byte_value <= 8'd0;
            send_gap <= 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                deframe_step(mbd_pkg::cmd_t'(item_ch.command), item_ch.byte_value);
                accepted_count++;
                if ($urandom_range(0, 149) == 0)
                    send_burst = ~send_burst;
            end
            if (item_ch.valid && !item_ch.ready)
                ;
            else if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                item_ch.valid <= 1'b0;
            end
            else
            begin
                while (pending_items.size() > 0 && pending_items[0].hold &&
                       expected_events.size() == 0)
                    void'(pending_items.pop_front());
                if (pending_items.size() > 0 && !pending_items[0].hold)
                begin
                    item_ch.command <= pending_items[0].cmd;
                    item_ch.byte_value <= pending_items[0].val;
                    item_ch.valid <= 1'b1;
                    send_gap <= send_burst ? 0 : $urandom_range(0, 13);
                    void'(pending_items.pop_front());
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver and checker.
    always @(posedge clk or negedge rst_n)
    begin
        frame_event_t ev;
        int           wait_next;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            wait_next = recv_gap;
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_events.size() == 0)
                    report($sformatf("unexpected result of kind %0d", result_ch.kind));
                else
                begin
                    ev = expected_events.pop_front();
                    if (result_ch.kind != ev.kind)
                        report($sformatf("kind %0d, predicted %0d", result_ch.kind, ev.kind));
                    if (result_ch.data_byte != ev.data)
                        report($sformatf("data_byte %0h, predicted %0h",
                                         result_ch.data_byte, ev.data));
                    if (result_ch.range_begin != ev.rbegin)
                        report($sformatf("range_begin %0d, predicted %0d",
                                         result_ch.range_begin, ev.rbegin));
                    if (result_ch.range_end != ev.rend)
                        report($sformatf("range_end %0d, predicted %0d",
                                         result_ch.range_end, ev.rend));
                    if (result_ch.chunk_offset != ev.offset)
                        report($sformatf("chunk_offset %0d, predicted %0d",
                                         result_ch.chunk_offset, ev.offset));
                    if (result_ch.total_bytes != ev.total)
                        report($sformatf("total_bytes %0d, predicted %0d",
                                         result_ch.total_bytes, ev.total));
                end
                if ($urandom_range(0, 149) == 0)
                    recv_burst = ~recv_burst;
                wait_next = recv_burst ? 0 : $urandom_range(0, 13);
            end
            if (wait_next != 0)
            begin
                recv_gap <= wait_next - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                recv_gap <= 0;
                result_ch.ready <= !rx_hold;
            end
        end
    end

    // One long hold on results while items keep coming, so the input stalls.
    initial
    begin
        while (accepted_count < 700)
            @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400)
            @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #4000000;
        $display("multipart_byterange_deframer_test: done, errors");
        $finish;
    end

    initial
    begin
        int bodies;
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.command = mbd_pkg::CMD_NONE;
        item_ch.byte_value = 8'd0;
        result_ch.ready = 1'b0;
        send_burst = 1'b0;
        recv_burst = 1'b0;
        clear_body();

        // Extreme boundary bytes, an ignored command, finish, then a byte after it.
        queue_item(mbd_pkg::CMD_START, 8'h00);
        queue_item(mbd_pkg::CMD_APPEND, 8'hFF);
        queue_item(mbd_pkg::CMD_APPEND, 8'h00);
        queue_item(mbd_pkg::CMD_NONE, 8'hFF);
        queue_text("--");
        queue_item(mbd_pkg::CMD_BODY, 8'hFF);
        queue_item(mbd_pkg::CMD_BODY, 8'h00);
        queue_text("--x");
        // Empty boundary, then a bad pair and a byte after the error.
        queue_item(mbd_pkg::CMD_START, 8'hFF);
        queue_text("\r\n----");
        queue_item(mbd_pkg::CMD_START, 8'h00);
        queue_text("-x\r");
        queue_drain();

        bodies = 0;
        while (stim_items < TARGET_ITEMS)
        begin
            build_body(bodies == 6);
            bodies++;
            if (bodies % 9 == 0)
                queue_drain();
        end

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        while (pending_items.size() > 0 || item_ch.valid)
            @(posedge clk);
        while (expected_events.size() > 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (error_count == 0)
            $display("multipart_byterange_deframer_test: done, clean");
        else
            $display("multipart_byterange_deframer_test: done, errors");
        $finish;
    end
endmodule
